[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while aresetn is high.
`define ASSERT_CLKED(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/bwct_pkg.sv]
// ----------------------------------------------------------------------------
// Binary weight convolution package
// Defaults, stream field layout and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwct_pkg;

    localparam int WIN_SIZE_DEF   = 3;
    localparam int FRAME_COLS_DEF = 32;
    localparam int FRAME_ROWS_DEF = 32;
    localparam int MAP_COUNT_DEF  = 16;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int FIELD_INDEX_W  = 4;
    localparam int FIELD_WEIGHT_W = 9;
    localparam int FIELD_THR_W    = 16;
    localparam int FIELD_PIXEL_W  = 16;
    localparam int MAP_BITS_W     = 16;

    localparam int IDX_LSB = 0;
    localparam int WGT_LSB = IDX_LSB + FIELD_INDEX_W;
    localparam int THR_LSB = WGT_LSB + FIELD_WEIGHT_W;
    localparam int PIX_LSB = THR_LSB + FIELD_THR_W;
    localparam int S_FIELDS_W = PIX_LSB + FIELD_PIXEL_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = MAP_BITS_W;

    localparam int FIFO_DEPTH = 8;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_PIXEL = 1'b1
    } func_t;

    typedef struct packed {
        logic [MAP_BITS_W-1:0] map_bits;
        logic                  frame_last;
    } result_t;

endpackage

`default_nettype wire

[src/bwct_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/bwct_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that decouples the pipeline from the output stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwct_fifo #(
    parameter int DEPTH = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bwct_pkg::result_t push_data,
    input  logic              pop,
    output logic              out_valid,
    output bwct_pkg::result_t head_data
);

    import bwct_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign out_valid = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

[src/binary_weight_conv_threshold_top.sv]
// ----------------------------------------------------------------------------
// Binary weight convolution with per-map threshold
// Streams a raster frame through a line RAM and a KxK window and emits one
// bit per output map for every full window.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while s_tready is high, pixels and
// table loads alike. A taken pixel goes through the line RAM read, then the
// window update and write-back, then the row sums, and then the totals and
// threshold compare that feed the result queue. The line RAM holds FRAME_COLS
// words of WIN_SIZE-1 pixels and is read when a pixel is taken and written
// back in the cycle after. Results wait in an eight-entry queue, and
// s_tready drops only while that queue plus the results in flight would
// overflow it, so a sink that takes one result per cycle never stalls the
// source. The first WIN_SIZE-1 rows and columns of each frame give no result.
`timescale 1ns / 1ps
`default_nettype none

module binary_weight_conv_threshold_top #(
    parameter int WIN_SIZE   = bwct_pkg::WIN_SIZE_DEF,
    parameter int FRAME_COLS = bwct_pkg::FRAME_COLS_DEF,
    parameter int FRAME_ROWS = bwct_pkg::FRAME_ROWS_DEF,
    parameter int MAP_COUNT  = bwct_pkg::MAP_COUNT_DEF,
    parameter int PIXEL_BITS = bwct_pkg::PIXEL_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_index, weight_bits, threshold_value, pixel, zero padding
    input  logic [bwct_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // map_bits
    output logic [bwct_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    import bwct_pkg::*;

    localparam int WIN_AREA   = WIN_SIZE * WIN_SIZE;
    localparam int STORE_ROWS = WIN_SIZE - 1;
    localparam int COL_W      = $clog2(FRAME_COLS);
    localparam int ROW_W      = $clog2(FRAME_ROWS);
    localparam int LANES      = (MAP_COUNT < MAP_BITS_W) ? MAP_COUNT : MAP_BITS_W;
    localparam int RSUM_W     = PIXEL_BITS + $clog2(WIN_SIZE) + 1;
    localparam int SUM_W      = PIXEL_BITS + $clog2(WIN_AREA) + 1;
    localparam int CMP_W      = (SUM_W > FIELD_THR_W) ? SUM_W : FIELD_THR_W;
    localparam int LINE_W     = STORE_ROWS * PIXEL_BITS;
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    // Input fields.
    logic [FIELD_INDEX_W-1:0]         s_entry_index;
    logic [FIELD_WEIGHT_W-1:0]        s_weight_bits;
    logic signed [FIELD_THR_W-1:0]    s_threshold_value;
    logic [FIELD_PIXEL_W-1:0]         s_pixel;
    logic signed [PIXEL_BITS-1:0]     px_in;
    logic [WIN_AREA-1:0]              wgt_in;

    assign s_entry_index     = s_tdata[IDX_LSB +: FIELD_INDEX_W];
    assign s_weight_bits     = s_tdata[WGT_LSB +: FIELD_WEIGHT_W];
    assign s_threshold_value = s_tdata[THR_LSB +: FIELD_THR_W];
    assign s_pixel           = s_tdata[PIX_LSB +: FIELD_PIXEL_W];

    generate
        if (PIXEL_BITS <= FIELD_PIXEL_W) begin : g_px_trunc
            assign px_in = s_pixel[PIXEL_BITS-1:0];
        end else begin : g_px_ext
            assign px_in = {{(PIXEL_BITS - FIELD_PIXEL_W){1'b0}}, s_pixel};
        end
        if (WIN_AREA <= FIELD_WEIGHT_W) begin : g_wgt_trunc
            assign wgt_in = s_weight_bits[WIN_AREA-1:0];
        end else begin : g_wgt_ext
            assign wgt_in = {{(WIN_AREA - FIELD_WEIGHT_W){1'b0}}, s_weight_bits};
        end
    endgenerate

    logic s_accept, pix_acc, ld_acc, pop;

    assign s_accept = s_tvalid && s_tready;
    assign pix_acc  = s_accept && (func_t'(s_tuser) == FUNC_PIXEL);
    assign ld_acc   = s_accept && (func_t'(s_tuser) == FUNC_LOAD);

    // Frame position.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             col_last, row_last, emit_now, last_now;

    assign col_last = (col_reg == COL_W'(FRAME_COLS - 1));
    assign row_last = (row_reg == ROW_W'(FRAME_ROWS - 1));
    assign emit_now = (int'(row_reg) >= WIN_SIZE - 1) && (int'(col_reg) >= WIN_SIZE - 1);
    assign last_now = row_last && col_last;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_acc) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    // Result credit: results taken in but not yet delivered.
    logic [OCC_W-1:0] occ_reg, occ_next;

    assign occ_next = occ_reg + OCC_W'(pix_acc && emit_now) - OCC_W'(pop);
    assign s_tready = (occ_reg < OCC_W'(FIFO_DEPTH));

    // Stage 1: line RAM read data is valid.
    logic                         pv1_reg, emit1_reg, last1_reg;
    logic [COL_W-1:0]             col1_reg;
    logic signed [PIXEL_BITS-1:0] px1_reg;
    logic                         ld1_reg;
    logic [FIELD_INDEX_W-1:0]     ldidx1_reg;
    logic [WIN_AREA-1:0]          ldw1_reg;
    logic signed [FIELD_THR_W-1:0] ldthr1_reg;

    // Stage 2: window holds the current pixel's neighborhood.
    logic v2_reg, last2_reg;

    // Stage 3: row sums registered.
    logic v3_reg, last3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            occ_reg <= '0;
            pv1_reg <= 1'b0;
            ld1_reg <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            occ_reg <= occ_next;
            pv1_reg <= pix_acc;
            ld1_reg <= ld_acc;
            v2_reg  <= pv1_reg && emit1_reg;
            v3_reg  <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        emit1_reg  <= emit_now;
        last1_reg  <= last_now;
        col1_reg   <= col_reg;
        px1_reg    <= px_in;
        ldidx1_reg <= s_entry_index;
        ldw1_reg   <= wgt_in;
        ldthr1_reg <= s_threshold_value;
        last2_reg  <= last1_reg;
        last3_reg  <= last2_reg;
    end

    // Line RAM: one word per column, row i of the store at bits i*PIXEL_BITS.
    logic [LINE_W-1:0] line_rd, line_wr;

    always_comb begin
        line_wr = line_rd;
        for (int i = 0; i < STORE_ROWS - 1; i++) begin
            line_wr[i*PIXEL_BITS +: PIXEL_BITS] = line_rd[(i+1)*PIXEL_BITS +: PIXEL_BITS];
        end
        line_wr[(STORE_ROWS-1)*PIXEL_BITS +: PIXEL_BITS] = px1_reg;
    end

    bwct_ram #(
        .WIDTH (LINE_W),
        .DEPTH (FRAME_COLS)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (pv1_reg),
        .wr_addr (col1_reg),
        .wr_data (line_wr),
        .rd_en   (pix_acc),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // Window: column WIN_SIZE-1 is the newest, row WIN_SIZE-1 the current row.
    logic signed [PIXEL_BITS-1:0] win_reg  [WIN_SIZE][WIN_SIZE];
    logic signed [PIXEL_BITS-1:0] win_next [WIN_SIZE][WIN_SIZE];

    always_comb begin
        win_next = win_reg;
        if (pv1_reg) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                for (int j = 0; j < WIN_SIZE - 1; j++) begin
                    win_next[i][j] = win_reg[i][j+1];
                end
            end
            for (int i = 0; i < STORE_ROWS; i++) begin
                win_next[i][WIN_SIZE-1] = line_rd[i*PIXEL_BITS +: PIXEL_BITS];
            end
            win_next[WIN_SIZE-1][WIN_SIZE-1] = px1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    // Weight and threshold tables, written in step with the pipeline.
    logic [WIN_AREA-1:0]           wgt_reg [LANES];
    logic signed [FIELD_THR_W-1:0] thr_reg [LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int f = 0; f < LANES; f++) begin
                wgt_reg[f] <= '0;
                thr_reg[f] <= '0;
            end
        end else begin
            for (int f = 0; f < LANES; f++) begin
                if (ld1_reg && (ldidx1_reg == FIELD_INDEX_W'(f))) begin
                    wgt_reg[f] <= ldw1_reg;
                    thr_reg[f] <= ldthr1_reg;
                end
            end
        end
    end

    // Row sums per map.
    logic signed [RSUM_W-1:0]      rsum_next [LANES][WIN_SIZE];
    logic signed [RSUM_W-1:0]      rsum_reg  [LANES][WIN_SIZE];
    logic signed [FIELD_THR_W-1:0] thr3_reg  [LANES];

    always_comb begin
        logic signed [RSUM_W-1:0] acc;
        logic signed [RSUM_W-1:0] term;
        for (int f = 0; f < LANES; f++) begin
            for (int i = 0; i < WIN_SIZE; i++) begin
                acc = '0;
                for (int j = 0; j < WIN_SIZE; j++) begin
                    term = RSUM_W'(win_reg[i][j]);
                    acc  = wgt_reg[f][i*WIN_SIZE + j] ? acc + term : acc - term;
                end
                rsum_next[f][i] = acc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rsum_reg <= rsum_next;
        thr3_reg <= thr_reg;
    end

    // Totals and threshold compare.
    logic [MAP_BITS_W-1:0] map_bits;

    always_comb begin
        logic signed [SUM_W-1:0] tot;
        map_bits = '0;
        for (int f = 0; f < LANES; f++) begin
            tot = '0;
            for (int i = 0; i < WIN_SIZE; i++) begin
                tot = tot + SUM_W'(rsum_reg[f][i]);
            end
            map_bits[f] = (CMP_W'(tot) >= CMP_W'(thr3_reg[f]));
        end
    end

    // Output queue.
    result_t push_data, head_data;

    always_comb begin
        push_data.map_bits   = map_bits;
        push_data.frame_last = last3_reg;
    end

    assign pop = m_tvalid && m_tready;

    bwct_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v3_reg),
        .push_data (push_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .head_data (head_data)
    );

    assign m_tdata = head_data.map_bits;
    assign m_tlast = head_data.frame_last;

endmodule

`default_nettype wire

[src/bwct_checker.sv]
// ----------------------------------------------------------------------------
// Port checker
// Watches the stream ports of the convolution block and checks reset
// behavior, output stability and the position of the end-of-frame flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bwct_checker #(
    parameter int WIN_SIZE   = bwct_pkg::WIN_SIZE_DEF,
    parameter int FRAME_COLS = bwct_pkg::FRAME_COLS_DEF,
    parameter int FRAME_ROWS = bwct_pkg::FRAME_ROWS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bwct_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    import bwct_pkg::*;

    localparam int OUT_ROWS = (FRAME_ROWS >= WIN_SIZE) ? FRAME_ROWS - WIN_SIZE + 1 : 1;
    localparam int OUT_COLS = (FRAME_COLS >= WIN_SIZE) ? FRAME_COLS - WIN_SIZE + 1 : 1;
    localparam int OUT_PER_FRAME = OUT_ROWS * OUT_COLS;
    localparam int POS_W = $clog2(OUT_PER_FRAME) + 1;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pos_end;

    assign pos_end = (pos_reg == POS_W'(OUT_PER_FRAME - 1));

    always_comb begin
        pos_next = pos_reg;
        if (m_tvalid && m_tready) begin
            pos_next = pos_end ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    `ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid && s_tready, "reset left the block busy")
    `ASSERT_CLKED(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")
    `ASSERT_CLKED(a_last_pos, m_tvalid |-> (m_tlast == pos_end), "end-of-frame flag on wrong result")

endmodule

bind binary_weight_conv_threshold_top bwct_checker #(
    .WIN_SIZE   (WIN_SIZE),
    .FRAME_COLS (FRAME_COLS),
    .FRAME_ROWS (FRAME_ROWS)
) u_bwct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[sim/tb_binary_weight_conv_threshold_top.sv]
// ----------------------------------------------------------------------------
// Binary weight convolution testbench
// Streams table loads and raster pixels into the block and checks every
// result against a cycle-free model of the window, weight and threshold
// tables, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_weight_conv_threshold_top;

    import bwct_pkg::*;

    localparam int K          = WIN_SIZE_DEF;
    localparam int COLS       = FRAME_COLS_DEF;
    localparam int ROWS       = FRAME_ROWS_DEF;
    localparam int MAPS       = MAP_COUNT_DEF;
    localparam int RAND_ITEMS = 2000;
    localparam int CALM_ITEMS = 300;
    localparam int HOLD_AT    = 500;
    localparam int DRAIN_AT   = 1100;
    localparam int HOLD_LEN   = 64;
    localparam int LIMIT      = 500000;
    localparam int DIR_N      = 20;

    typedef struct packed {
        func_t       func;
        logic [3:0]  idx;
        logic [8:0]  wgt;
        logic [15:0] thr;
        logic [15:0] pix;
    } item_t;

    typedef struct packed {
        item_t   it;
        bit      typed;
        bit      typed_emit;
        result_t typed_res;
    } dir_row_t;

    // Loads and the first pixels of row zero carry a typed expectation of no result.
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{'{FUNC_LOAD,  4'd0,  9'h000, 16'h8000, 16'hFFFF}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd15, 9'h1FF, 16'h7FFF, 16'h0000}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd5,  9'h155, 16'h0000, 16'hFFFF}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd10, 9'h0AA, 16'hFFFF, 16'h0000}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd1,  9'h1FF, 16'h0000, 16'h5555}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd2,  9'h000, 16'h0000, 16'hAAAA}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd3,  9'h100, 16'h0001, 16'h0000}, 1'b1, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd4,  9'h001, 16'hFFFF, 16'h0000}, 1'b1, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'hF,  9'h1FF, 16'hFFFF, 16'h7FFF}, 1'b1, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h8000}, 1'b1, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'hA,  9'h0AA, 16'h5555, 16'h0000}, 1'b0, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h5,  9'h155, 16'hAAAA, 16'hFFFF}, 1'b0, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h0001}, 1'b0, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h5555}, 1'b0, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'hAAAA}, 1'b0, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd6,  9'h0F0, 16'h1234, 16'h7FFF}, 1'b1, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h7FFF}, 1'b0, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h8000}, 1'b0, 1'b0, '0},
        '{'{FUNC_LOAD,  4'd15, 9'h000, 16'h7FFF, 16'h8000}, 1'b1, 1'b0, '0},
        '{'{FUNC_PIXEL, 4'h0,  9'h000, 16'h0000, 16'h7FFF}, 1'b0, 1'b0, '0}
    };

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [0:0]           s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic signed [15:0] line_mem [K-1][COLS];
    logic signed [15:0] win      [K*K];
    logic [8:0]         wgt_tab  [MAPS];
    logic signed [15:0] thr_tab  [MAPS];
    int                 col_pos;
    int                 row_pos;

    result_t map_results_q [$];
    result_t head;
    int      err_count = 0;
    int      cycle_cnt = 0;
    bit      hold_req  = 1'b0;
    bit      calm      = 1'b0;

    binary_weight_conv_threshold_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("** binary_weight_conv_threshold_top: FAILED **");
            $finish;
        end
    end

    // Updates the convolution state for one accepted transaction.
    task automatic conv_step(input item_t it, output bit emits, output result_t res);
        int sum;
        int c;
        int r;
        c = col_pos;
        r = row_pos;
        emits = 1'b0;
        res = '0;
        if (it.func == FUNC_LOAD) begin
            if (int'(it.idx) < MAPS) begin
                wgt_tab[it.idx] = it.wgt;
                thr_tab[it.idx] = it.thr;
            end
        end else begin
            for (int i = 0; i < K; i++)
                for (int j = 0; j < K - 1; j++)
                    win[i*K+j] = win[i*K+j+1];
            for (int i = 0; i < K - 1; i++)
                win[i*K+K-1] = line_mem[i][c];
            for (int i = 0; i < K - 2; i++)
                line_mem[i][c] = line_mem[i+1][c];
            win[K*K-1] = it.pix;
            line_mem[K-2][c] = it.pix;
            for (int f = 0; f < MAPS; f++) begin
                sum = 0;
                for (int i = 0; i < K*K; i++) begin
                    if (wgt_tab[f][i])
                        sum += int'(win[i]);
                    else
                        sum -= int'(win[i]);
                end
                if (f < M_TDATA_W && sum >= int'(thr_tab[f]))
                    res.map_bits[f] = 1'b1;
            end
            emits = (r >= K - 1) && (c >= K - 1);
            res.frame_last = (r == ROWS - 1) && (c == COLS - 1);
            if (c + 1 >= COLS) begin
                col_pos = 0;
                row_pos = (r + 1 >= ROWS) ? 0 : r + 1;
            end else begin
                col_pos = c + 1;
            end
        end
    endtask

    task automatic push_item(input item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[IDX_LSB +: FIELD_INDEX_W]  = it.idx;
        d[WGT_LSB +: FIELD_WEIGHT_W] = it.wgt;
        d[THR_LSB +: FIELD_THR_W]    = it.thr;
        d[PIX_LSB +: FIELD_PIXEL_W]  = it.pix;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic pause_input(input int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    initial begin : sink_side
        int n;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_req) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 16);
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                n = $urandom_range(1, 16);
                @(negedge aclk);
                m_tready <= 1'b1;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (map_results_q.size() == 0) begin
                $error("unexpected result: map_bits %h, tlast %b", m_tdata, m_tlast);
                err_count++;
            end else begin
                head = map_results_q.pop_front();
                if (m_tdata !== head.map_bits) begin
                    $error("map_bits: expected %h, actual %h", head.map_bits, m_tdata);
                    err_count++;
                end
                if (m_tlast !== head.frame_last) begin
                    $error("frame_last: expected %b, actual %b", head.frame_last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin : source_side
        item_t   it;
        bit      emits;
        result_t res;
        int      pix_mode;
        int      sel;
        for (int r = 0; r < K - 1; r++)
            for (int c = 0; c < COLS; c++)
                line_mem[r][c] = '0;
        for (int i = 0; i < K*K; i++)
            win[i] = '0;
        for (int f = 0; f < MAPS; f++) begin
            wgt_tab[f] = '0;
            thr_tab[f] = '0;
        end
        col_pos  = 0;
        row_pos  = 0;
        pix_mode = 0;
        while (!aresetn) @(posedge aclk);

        for (int k = 0; k < DIR_N; k++) begin
            push_item(DIR_TAB[k].it);
            conv_step(DIR_TAB[k].it, emits, res);
            if (DIR_TAB[k].typed) begin
                emits = DIR_TAB[k].typed_emit;
                res   = DIR_TAB[k].typed_res;
            end
            if (emits)
                map_results_q.push_back(res);
        end

        for (int k = 0; k < RAND_ITEMS; k++) begin
            calm = (k >= RAND_ITEMS - CALM_ITEMS);
            if (k == HOLD_AT)
                hold_req = 1'b1;
            if (k == DRAIN_AT) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                while (map_results_q.size() != 0) @(negedge aclk);
            end else if (!calm && !hold_req && $urandom_range(0, 5) == 0) begin
                pause_input($urandom_range(1, 16));
            end
            if (k % 128 == 0)
                pix_mode = $urandom_range(0, 3);

            it.func = ($urandom_range(0, 11) == 0) ? FUNC_LOAD : FUNC_PIXEL;
            it.idx  = 4'($urandom);
            it.wgt  = 9'($urandom);
            case ($urandom_range(0, 3))
                0:       it.thr = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                1:       it.thr = 16'(int'($urandom_range(0, 64)) - 32);
                default: it.thr = 16'($urandom);
            endcase
            sel = (pix_mode == 3) ? $urandom_range(0, 2) : pix_mode;
            case (sel)
                1:       it.pix = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                2:       it.pix = 16'(int'($urandom_range(0, 16)) - 8);
                default: it.pix = 16'($urandom);
            endcase

            push_item(it);
            conv_step(it, emits, res);
            if (emits)
                map_results_q.push_back(res);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (map_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0) begin
            $display("** binary_weight_conv_threshold_top: PASSED **");
        end else begin
            $display("** binary_weight_conv_threshold_top: FAILED **");
        end
        $finish;
    end

endmodule
